// ===== hdl/lgec_pkg.sv =====
package lgec_pkg;

  localparam int COUNT_WIDTH_DEF = 24;
  localparam int NUM_MOTORS_DEF  = 3;

  localparam int REQ_W   = 2;
  localparam int MOTOR_W = 2;
  localparam int DIR_W   = 2;
  localparam int MASK_W  = 3;
  localparam int CFG_AW  = 2;
  localparam int CFG_DW  = 3;

  localparam logic [REQ_W-1:0] REQ_LIMIT   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PULSE_A = 2'd1;
  localparam logic [REQ_W-1:0] REQ_PULSE_B = 2'd2;

  localparam logic [DIR_W-1:0] DIR_OFF = 2'd0;
  localparam logic [DIR_W-1:0] DIR_CW  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_CCW = 2'd2;

  localparam logic [CFG_AW-1:0] CFG_UP_ON_CW    = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_LIMIT_LOAD  = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_M0_A_ENABLE = 2'd2;

  localparam logic [MASK_W-1:0] UP_ON_CW_RST   = 3'd5;
  localparam logic [MASK_W-1:0] LIMIT_LOAD_RST = 3'd6;

  localparam logic [MOTOR_W-1:0] MOTOR_NO_MASK = 2'd3;

  // state write controls for one item
  typedef struct packed {
    logic wr_a;
    logic wr_b;
    logic wr_flag;
    logic stop;
  } lgec_ctrl_t;

  // motors past the mask width have no mask bit
  function automatic logic mask_bit(logic [MASK_W-1:0] mask, logic [MOTOR_W-1:0] m);
    logic bit_val;
    bit_val = 1'b0;
    if (m != MOTOR_NO_MASK) begin
      bit_val = mask[m];
    end
    return bit_val;
  endfunction

endpackage

// ===== hdl/limit_gated_encoder_counters_core.sv =====
// channel   signals                                       direction
// in        in_valid in_ready req_type motor              input item
//           switch_level direction
// out       out_valid out_ready motor_out count_a_out     result item
//           count_b_out limit_reached stop_drive
// cfg       cfg_we cfg_addr cfg_wdata                     register write
//
// One item per cycle unless out_ready stalls; the item register feeds the result.
// The item register reads the motor's counts and flag, and the update and the
// result register load land on the same edge, so the next item sees it.
// Reset loads all counts and limit flags with 1 and the registers with defaults.
// A stalled result holds; input keeps flowing while the item register can move.
module limit_gated_encoder_counters_core #(
  parameter int COUNT_WIDTH = lgec_pkg::COUNT_WIDTH_DEF,
  parameter int NUM_MOTORS  = lgec_pkg::NUM_MOTORS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [lgec_pkg::REQ_W-1:0]   req_type,
  input  logic [lgec_pkg::MOTOR_W-1:0] motor,
  input  logic                         switch_level,
  input  logic [lgec_pkg::DIR_W-1:0]   direction,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lgec_pkg::MOTOR_W-1:0] motor_out,
  output logic [COUNT_WIDTH-1:0]       count_a_out,
  output logic [COUNT_WIDTH-1:0]       count_b_out,
  output logic                         limit_reached,
  output logic                         stop_drive,
  input  logic                         cfg_we,
  input  logic [lgec_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [lgec_pkg::CFG_DW-1:0]  cfg_wdata
);
  import lgec_pkg::*;

  localparam int IDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

  logic [MASK_W-1:0] up_on_cw_mask;
  logic [MASK_W-1:0] limit_load_mask;
  logic              m0_a_enable;

  logic               s1_valid;
  logic [REQ_W-1:0]   s1_req;
  logic [MOTOR_W-1:0] s1_motor;
  logic               s1_level;
  logic [DIR_W-1:0]   s1_dir;

  logic                   advance;
  logic                   s1_fire;
  logic                   in_range;
  logic [IDX_W-1:0]       idx;
  logic [COUNT_WIDTH-1:0] cur_count_a;
  logic [COUNT_WIDTH-1:0] cur_count_b;
  logic                   cur_flag;
  lgec_ctrl_t             ctrl;
  logic [COUNT_WIDTH-1:0] new_count_a;
  logic [COUNT_WIDTH-1:0] new_count_b;
  logic                   new_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      up_on_cw_mask   <= UP_ON_CW_RST;
      limit_load_mask <= LIMIT_LOAD_RST;
      m0_a_enable     <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_UP_ON_CW:    up_on_cw_mask   <= cfg_wdata;
        CFG_LIMIT_LOAD:  limit_load_mask <= cfg_wdata;
        CFG_M0_A_ENABLE: m0_a_enable     <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;
  assign s1_fire  = s1_valid && advance;
  assign in_range = 32'(s1_motor) < NUM_MOTORS;
  assign idx      = IDX_W'(s1_motor);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_req   <= req_type;
      s1_motor <= motor;
      s1_level <= switch_level;
      s1_dir   <= direction;
    end
  end

  lgec_state #(
    .COUNT_WIDTH(COUNT_WIDTH),
    .NUM_MOTORS (NUM_MOTORS),
    .IDX_W      (IDX_W)
  ) u_state (
    .clk       (clk),
    .rst       (rst),
    .idx       (idx),
    .wr_en     (s1_fire && in_range),
    .ctrl      (ctrl),
    .wr_count_a(new_count_a),
    .wr_count_b(new_count_b),
    .wr_flag   (new_flag),
    .rd_count_a(cur_count_a),
    .rd_count_b(cur_count_b),
    .rd_flag   (cur_flag)
  );

  lgec_update #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_update (
    .req_type       (s1_req),
    .motor          (s1_motor),
    .switch_level   (s1_level),
    .direction      (s1_dir),
    .up_on_cw_mask  (up_on_cw_mask),
    .limit_load_mask(limit_load_mask),
    .m0_a_enable    (m0_a_enable),
    .cur_count_a    (cur_count_a),
    .cur_count_b    (cur_count_b),
    .cur_flag       (cur_flag),
    .ctrl           (ctrl),
    .new_count_a    (new_count_a),
    .new_count_b    (new_count_b),
    .new_flag       (new_flag)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      motor_out     <= s1_motor;
      count_a_out   <= in_range ? new_count_a : '0;
      count_b_out   <= in_range ? new_count_b : '0;
      limit_reached <= in_range && new_flag;
      stop_drive    <= in_range && ctrl.stop;
    end
  end

  a_stop_has_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && stop_drive |-> limit_reached)
    else $error("stop_drive without limit flag");

  a_out_of_range_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (32'(motor_out) >= NUM_MOTORS) |->
      (count_a_out == '0) && (count_b_out == '0) && !limit_reached && !stop_drive)
    else $error("out of range motor reported state");

  a_item_moves: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> out_valid)
    else $error("item lost between stages");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && out_valid && !out_ready)
    else $error("input stalled with room");

endmodule

// ===== hdl/lgec_state.sv =====
module lgec_state #(
  parameter int COUNT_WIDTH = lgec_pkg::COUNT_WIDTH_DEF,
  parameter int NUM_MOTORS  = lgec_pkg::NUM_MOTORS_DEF,
  parameter int IDX_W       = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [IDX_W-1:0]       idx,
  input  logic                   wr_en,
  input  lgec_pkg::lgec_ctrl_t   ctrl,
  input  logic [COUNT_WIDTH-1:0] wr_count_a,
  input  logic [COUNT_WIDTH-1:0] wr_count_b,
  input  logic                   wr_flag,
  output logic [COUNT_WIDTH-1:0] rd_count_a,
  output logic [COUNT_WIDTH-1:0] rd_count_b,
  output logic                   rd_flag
);
  import lgec_pkg::*;

  logic [COUNT_WIDTH-1:0] count_a [NUM_MOTORS];
  logic [COUNT_WIDTH-1:0] count_b [NUM_MOTORS];
  logic [NUM_MOTORS-1:0]  flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_MOTORS; i++) begin
        count_a[i] <= COUNT_WIDTH'(1);
        count_b[i] <= COUNT_WIDTH'(1);
      end
      flag <= '1;
    end else if (wr_en) begin
      if (ctrl.wr_a) begin
        count_a[idx] <= wr_count_a;
      end
      if (ctrl.wr_b) begin
        count_b[idx] <= wr_count_b;
      end
      if (ctrl.wr_flag) begin
        flag[idx] <= wr_flag;
      end
    end
  end

  assign rd_count_a = count_a[idx];
  assign rd_count_b = count_b[idx];
  assign rd_flag    = flag[idx];

endmodule

// ===== hdl/lgec_update.sv =====
module lgec_update #(
  parameter int COUNT_WIDTH = lgec_pkg::COUNT_WIDTH_DEF
) (
  input  logic [lgec_pkg::REQ_W-1:0]   req_type,
  input  logic [lgec_pkg::MOTOR_W-1:0] motor,
  input  logic                         switch_level,
  input  logic [lgec_pkg::DIR_W-1:0]   direction,
  input  logic [lgec_pkg::MASK_W-1:0]  up_on_cw_mask,
  input  logic [lgec_pkg::MASK_W-1:0]  limit_load_mask,
  input  logic                         m0_a_enable,
  input  logic [COUNT_WIDTH-1:0]       cur_count_a,
  input  logic [COUNT_WIDTH-1:0]       cur_count_b,
  input  logic                         cur_flag,
  output lgec_pkg::lgec_ctrl_t         ctrl,
  output logic [COUNT_WIDTH-1:0]       new_count_a,
  output logic [COUNT_WIDTH-1:0]       new_count_b,
  output logic                         new_flag
);
  import lgec_pkg::*;

  logic up_cw;
  logic load;
  logic a_enabled;
  logic [DIR_W-1:0] up_dir;
  logic [DIR_W-1:0] down_dir;
  logic [COUNT_WIDTH-1:0] pulse_a;
  logic [COUNT_WIDTH-1:0] pulse_b;
  logic [COUNT_WIDTH-1:0] load_val;

  function automatic logic [COUNT_WIDTH-1:0] pulse_step(
    logic [COUNT_WIDTH-1:0] cnt,
    logic [DIR_W-1:0]       dir,
    logic [DIR_W-1:0]       up_d,
    logic [DIR_W-1:0]       down_d
  );
    logic [COUNT_WIDTH-1:0] res;
    res = cnt;
    if (dir == up_d) begin
      if (cnt != '1) begin
        res = cnt + COUNT_WIDTH'(1);
      end
    end else if (dir == down_d) begin
      if (cnt > COUNT_WIDTH'(1)) begin
        res = cnt - COUNT_WIDTH'(1);
      end
    end
    return res;
  endfunction

  assign up_cw     = mask_bit(up_on_cw_mask, motor);
  assign load      = mask_bit(limit_load_mask, motor);
  assign a_enabled = (motor != MOTOR_W'(0)) || m0_a_enable;
  assign up_dir    = up_cw ? DIR_CW : DIR_CCW;
  assign down_dir  = up_cw ? DIR_CCW : DIR_CW;
  assign pulse_a   = pulse_step(cur_count_a, direction, up_dir, down_dir);
  assign pulse_b   = pulse_step(cur_count_b, direction, up_dir, down_dir);
  assign load_val  = switch_level ? '0 : COUNT_WIDTH'(1);

  always_comb begin
    ctrl        = '0;
    new_count_a = cur_count_a;
    new_count_b = cur_count_b;
    new_flag    = cur_flag;
    unique case (req_type)
      REQ_LIMIT: begin
        ctrl.wr_flag = 1'b1;
        ctrl.stop    = switch_level;
        new_flag     = switch_level;
        if (load) begin
          ctrl.wr_a   = 1'b1;
          ctrl.wr_b   = 1'b1;
          new_count_a = load_val;
          new_count_b = load_val;
        end
      end
      REQ_PULSE_A: begin
        if (a_enabled && !cur_flag) begin
          ctrl.wr_a   = 1'b1;
          new_count_a = pulse_a;
        end
      end
      REQ_PULSE_B: begin
        if (!cur_flag) begin
          ctrl.wr_b   = 1'b1;
          new_count_b = pulse_b;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
